// ----- src/uniform_histogram_binner_unit_assert.svh -----
// Assertion macros for the histogram binner
`ifndef UNIFORM_HISTOGRAM_BINNER_UNIT_ASSERT_SVH
`define UNIFORM_HISTOGRAM_BINNER_UNIT_ASSERT_SVH

// same-cycle implication
`define UHB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UHB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/uhb_pkg.sv -----
`timescale 1ns / 1ps

package uhb_pkg;

  localparam int unsigned MAX_BUCKETS = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_BUCKETS);
  localparam int unsigned NB_W        = IDX_W + 1;
  localparam int unsigned PROD_W      = VAL_W + NB_W;
  localparam int unsigned DVS_W       = VAL_W + IDX_W - 1;
  localparam int unsigned STEP_W      = $clog2(IDX_W);
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned BT_W        = 7;

  localparam logic signed [VAL_W-1:0] RANGE_LOW_RST    = 32'sd0;
  localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST   = 32'sd3072;
  localparam logic [BT_W-1:0]         BUCKET_TOTAL_RST = 7'd12;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW    = 2'd0,
    REG_RANGE_HIGH   = 2'd1,
    REG_BUCKET_TOTAL = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_FETCH,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic mul;
    logic div;
    logic fetch;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             div_last;
  } dp_sts_t;

endpackage

// ----- src/uhb_ctrl.sv -----
`timescale 1ns / 1ps

module uhb_ctrl import uhb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_ADD:  state_d = sts_i.in_range ? ST_MUL : ST_COMMIT;
          CMD_READ: state_d = ST_FETCH;
          default:  state_d = ST_COMMIT;
        endcase
      end
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.latch  = in_valid_i;
      end
      ST_MUL:    cmd_o.mul    = 1'b1;
      ST_DIV:    cmd_o.div    = 1'b1;
      ST_FETCH:  cmd_o.fetch  = 1'b1;
      ST_COMMIT: cmd_o.commit = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/uhb_dp.sv -----
`timescale 1ns / 1ps

module uhb_dp import uhb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic signed [VAL_W-1:0] sample_i,
  input  logic [IDX_W-1:0]     bucket_select_i,
  output logic                 accepted_o,
  output logic [IDX_W-1:0]     bucket_index_o,
  output logic [COUNT_W-1:0]   bucket_value_o,
  output logic [COUNT_W-1:0]   running_total_o,
  output logic [IDX_W-1:0]     peak_bucket_o,
  output logic [COUNT_W-1:0]   peak_count_o
);

  logic signed [VAL_W-1:0] range_low_q, range_high_q;
  logic [BT_W-1:0]         bucket_total_q;
  logic [NB_W-1:0]         nb;

  logic [CMD_W-1:0]        cmd_q;
  logic signed [VAL_W-1:0] sample_q;
  logic [IDX_W-1:0]        sel_q;

  logic                    in_range;
  logic [VAL_W-1:0]        diff, width;
  logic [PROD_W-1:0]       prod;

  logic [PROD_W-1:0]       rem_q;
  logic [DVS_W-1:0]        dvs_q;
  logic [IDX_W-1:0]        quo_q;
  logic [STEP_W-1:0]       step_q;
  logic                    ge;

  logic [IDX_W-1:0]        bidx, addr_d, addr_q;
  logic [COUNT_W-1:0]      mem [MAX_BUCKETS];
  logic [COUNT_W-1:0]      rdata_q;
  logic [MAX_BUCKETS-1:0]  vld_q;
  logic                    vld_rd_q;
  logic [COUNT_W-1:0]      cur, new_cnt;

  logic                    acc_n, wr_en, clr;
  logic [IDX_W-1:0]        idx_n;
  logic [COUNT_W-1:0]      val_n;
  logic [COUNT_W-1:0]      total_q, total_d;
  logic [IDX_W-1:0]        peak_idx_q, peak_idx_d;
  logic [COUNT_W-1:0]      peak_val_q, peak_val_d;
  logic                    acc_q;
  logic [IDX_W-1:0]        idx_q;
  logic [COUNT_W-1:0]      val_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q    <= RANGE_LOW_RST;
      range_high_q   <= RANGE_HIGH_RST;
      bucket_total_q <= BUCKET_TOTAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RANGE_LOW:    range_low_q    <= cfg_data_i;
        REG_RANGE_HIGH:   range_high_q   <= cfg_data_i;
        REG_BUCKET_TOTAL: bucket_total_q <= cfg_data_i[BT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bucket_total_q == '0) begin
      nb = NB_W'(1);
    end else if (NB_W'(bucket_total_q) > NB_W'(MAX_BUCKETS)) begin
      nb = NB_W'(MAX_BUCKETS);
    end else begin
      nb = NB_W'(bucket_total_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q    <= command_i;
      sample_q <= sample_i;
      sel_q    <= bucket_select_i;
    end
  end

  assign in_range = (range_high_q > range_low_q) && (sample_q >= range_low_q) &&
                    (sample_q < range_high_q);
  assign diff  = sample_q - range_low_q;
  assign width = range_high_q - range_low_q;
  assign prod  = PROD_W'(diff) * PROD_W'(nb);

  // restoring divide, one quotient bit per cycle; quotient is below nb
  assign ge = rem_q >= PROD_W'(dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q  <= prod;
      dvs_q  <= {width, {(IDX_W-1){1'b0}}};
      quo_q  <= '0;
      step_q <= STEP_W'(IDX_W - 1);
    end else if (cmd_i.div) begin
      if (ge) rem_q <= rem_q - PROD_W'(dvs_q);
      dvs_q  <= dvs_q >> 1;
      quo_q  <= {quo_q[IDX_W-2:0], ge};
      step_q <= step_q - 1'b1;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.in_range = in_range;
  assign sts_o.div_last = (step_q == '0);

  // bucket store
  assign bidx   = ({1'b0, quo_q} >= nb) ? IDX_W'(nb - 1'b1) : quo_q;
  assign addr_d = (cmd_q == CMD_READ) ? sel_q : bidx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      addr_q   <= addr_d;
      rdata_q  <= mem[addr_d];
      vld_rd_q <= vld_q[addr_d];
    end
    if (wr_en) mem[addr_q] <= new_cnt;
  end

  assign cur     = vld_rd_q ? rdata_q : '0;
  assign new_cnt = (&cur) ? cur : cur + 1'b1;

  always_comb begin
    acc_n      = 1'b0;
    idx_n      = '0;
    val_n      = '0;
    wr_en      = 1'b0;
    clr        = 1'b0;
    total_d    = total_q;
    peak_idx_d = peak_idx_q;
    peak_val_d = peak_val_q;
    case (cmd_q)
      CMD_ADD: begin
        if (in_range) begin
          acc_n   = 1'b1;
          idx_n   = addr_q;
          val_n   = new_cnt;
          wr_en   = cmd_i.commit;
          total_d = (&total_q) ? total_q : total_q + 1'b1;
          if ((new_cnt > peak_val_q) ||
              ((new_cnt == peak_val_q) && (addr_q < peak_idx_q))) begin
            peak_val_d = new_cnt;
            peak_idx_d = addr_q;
          end
        end
      end
      CMD_CLEAR: begin
        acc_n      = 1'b1;
        clr        = cmd_i.commit;
        total_d    = '0;
        peak_idx_d = '0;
        peak_val_d = '0;
      end
      CMD_READ: begin
        idx_n = sel_q;
        if ({1'b0, sel_q} < nb) begin
          acc_n = 1'b1;
          val_n = cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      total_q    <= '0;
      peak_idx_q <= '0;
      peak_val_q <= '0;
    end else if (cmd_i.commit) begin
      if (clr) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      total_q    <= total_d;
      peak_idx_q <= peak_idx_d;
      peak_val_q <= peak_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      acc_q <= acc_n;
      idx_q <= idx_n;
      val_q <= val_n;
    end
  end

  // totals and peak only move on commit, together with the result register
  assign accepted_o      = acc_q;
  assign bucket_index_o  = idx_q;
  assign bucket_value_o  = val_q;
  assign running_total_o = total_q;
  assign peak_bucket_o   = peak_idx_q;
  assign peak_count_o    = peak_val_q;

endmodule

// ----- src/uniform_histogram_binner_unit.sv -----
// A counted sample passes through decode, multiply, 6 divide steps, store read
// and commit; a read through decode, store read and commit; others decode and commit.
// The block takes one transaction at a time: a new one is accepted only after the
// last has committed, and commit waits while a pending result is stalled.
// Reset (async, active low) empties every bucket via valid flags, zeroes the
// total and peak, and loads range 0..3072 with 12 buckets.
`timescale 1ns / 1ps
`include "uniform_histogram_binner_unit_assert.svh"

module uniform_histogram_binner_unit import uhb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [VAL_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [VAL_W-1:0] sample_i,
  input  logic [IDX_W-1:0]        bucket_select_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    accepted_o,
  output logic [IDX_W-1:0]        bucket_index_o,
  output logic [COUNT_W-1:0]      bucket_value_o,
  output logic [COUNT_W-1:0]      running_total_o,
  output logic [IDX_W-1:0]        peak_bucket_o,
  output logic [COUNT_W-1:0]      peak_count_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  uhb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  uhb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .sts_o           (dp_sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .sample_i        (sample_i),
    .bucket_select_i (bucket_select_i),
    .accepted_o      (accepted_o),
    .bucket_index_o  (bucket_index_o),
    .bucket_value_o  (bucket_value_o),
    .running_total_o (running_total_o),
    .peak_bucket_o   (peak_bucket_o),
    .peak_count_o    (peak_count_o)
  );

  `UHB_ASSERT_IMP(a_commit_free, ctrl_cmd.commit, !out_valid_o || !out_stall_i, "commit over pending result")
  `UHB_ASSERT_NXT(a_commit_valid, ctrl_cmd.commit, out_valid_o, "commit without result")
  `UHB_ASSERT_IMP(a_peak_max, out_valid_o && accepted_o, peak_count_o >= bucket_value_o, "peak below bucket")
  `UHB_ASSERT_IMP(a_total_peak, out_valid_o, running_total_o >= peak_count_o, "total below peak")

endmodule

// ----- tb/uhb_histogram_check.sv -----
`timescale 1ns / 1ps

module uhb_histogram_check import uhb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [VAL_W-1:0]     sample_i,
  input  logic [IDX_W-1:0]     bucket_select_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 accepted_i,
  input  logic [IDX_W-1:0]     bucket_index_i,
  input  logic [COUNT_W-1:0]   bucket_value_i,
  input  logic [COUNT_W-1:0]   running_total_i,
  input  logic [IDX_W-1:0]     peak_bucket_i,
  input  logic [COUNT_W-1:0]   peak_count_i,
  output int                   mismatches_o,
  output int                   outstanding_o
);

  typedef struct packed {
    logic               accepted;
    logic [IDX_W-1:0]   index;
    logic [COUNT_W-1:0] value;
    logic [COUNT_W-1:0] total;
    logic [IDX_W-1:0]   peak;
    logic [COUNT_W-1:0] peak_cnt;
  } bin_reply_t;

  logic signed [VAL_W-1:0] lo_q;
  logic signed [VAL_W-1:0] hi_q;
  logic [BT_W-1:0]         nb_q;
  logic [COUNT_W-1:0]      tally [MAX_BUCKETS];
  logic [COUNT_W-1:0]      sum_q;
  logic [COUNT_W-1:0]      peak_cnt_q;
  logic [IDX_W-1:0]        peak_q;
  bin_reply_t              replies_q [$];
  bin_reply_t              want;
  bin_reply_t              next_reply;
  int                      errs;

  function automatic bin_reply_t apply_op(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
                                          logic [IDX_W-1:0] sel);
    bin_reply_t  r;
    longint      span;
    longint      off;
    longint      b;
    int unsigned nb;
    r = '0;
    nb = (nb_q == 0) ? 1 : (nb_q > MAX_BUCKETS) ? MAX_BUCKETS : nb_q;
    case (cmd)
      CMD_ADD: begin
        span = longint'(hi_q) - longint'(lo_q);
        off = longint'(v) - longint'(lo_q);
        if (span > 0 && off >= 0 && off < span) begin
          b = (off * nb) / span;
          if (b >= nb) b = nb - 1;
          if (tally[b] != '1) tally[b] = tally[b] + 1'b1;
          if (sum_q != '1) sum_q = sum_q + 1'b1;
          if (tally[b] > peak_cnt_q || (tally[b] == peak_cnt_q && b < peak_q)) begin
            peak_cnt_q = tally[b];
            peak_q = b[IDX_W-1:0];
          end
          r.accepted = 1'b1;
          r.index = b[IDX_W-1:0];
          r.value = tally[b];
        end
      end
      CMD_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        sum_q = '0;
        peak_q = '0;
        peak_cnt_q = '0;
        r.accepted = 1'b1;
      end
      CMD_READ: begin
        r.index = sel;
        if (sel < nb) begin
          r.accepted = 1'b1;
          r.value = tally[sel];
        end
      end
      default: ;
    endcase
    r.total = sum_q;
    r.peak = peak_q;
    r.peak_cnt = peak_cnt_q;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [COUNT_W-1:0] want_v, logic [COUNT_W-1:0] got_v);
    if (want_v !== got_v) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q = RANGE_LOW_RST;
      hi_q = RANGE_HIGH_RST;
      nb_q = BUCKET_TOTAL_RST;
      foreach (tally[i]) tally[i] = '0;
      sum_q = '0;
      peak_q = '0;
      peak_cnt_q = '0;
      replies_q.delete();
      errs = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE_LOW:    lo_q = cfg_data_i;
          REG_RANGE_HIGH:   hi_q = cfg_data_i;
          REG_BUCKET_TOTAL: nb_q = cfg_data_i[BT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_q.size() == 0) begin
          errs++;
          $error("result with no transaction outstanding");
        end else begin
          want = replies_q.pop_front();
          cmp_field("accepted", COUNT_W'(want.accepted), COUNT_W'(accepted_i));
          cmp_field("bucket_index", COUNT_W'(want.index), COUNT_W'(bucket_index_i));
          cmp_field("bucket_value", want.value, bucket_value_i);
          cmp_field("running_total", want.total, running_total_i);
          cmp_field("peak_bucket", COUNT_W'(want.peak), COUNT_W'(peak_bucket_i));
          cmp_field("peak_count", want.peak_cnt, peak_count_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_reply = apply_op(command_i, sample_i, bucket_select_i);
        replies_q = {replies_q, next_reply};
      end
      mismatches_o <= errs;
      outstanding_o <= replies_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import uhb_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASES  = 17;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [VAL_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [CMD_W-1:0]     command = '0;
  logic [VAL_W-1:0]     sample = '0;
  logic [IDX_W-1:0]     bucket_sel = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 accepted;
  logic [IDX_W-1:0]     bucket_index;
  logic [COUNT_W-1:0]   bucket_value;
  logic [COUNT_W-1:0]   running_total;
  logic [IDX_W-1:0]     peak_bucket;
  logic [COUNT_W-1:0]   peak_count;

  int  mismatches;
  int  outstanding;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  quiet = 0;
  bit  hold_req = 1'b0;

  logic signed [VAL_W-1:0] cur_lo = RANGE_LOW_RST;
  logic signed [VAL_W-1:0] cur_hi = RANGE_HIGH_RST;

  uniform_histogram_binner_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .sample_i        (sample),
    .bucket_select_i (bucket_sel),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_o      (accepted),
    .bucket_index_o  (bucket_index),
    .bucket_value_o  (bucket_value),
    .running_total_o (running_total),
    .peak_bucket_o   (peak_bucket),
    .peak_count_o    (peak_count)
  );

  uhb_histogram_check u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .sample_i        (sample),
    .bucket_select_i (bucket_sel),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_i      (accepted),
    .bucket_index_i  (bucket_index),
    .bucket_value_i  (bucket_value),
    .running_total_i (running_total),
    .peak_bucket_i   (peak_bucket),
    .peak_count_i    (peak_count),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side; a hold request keeps it stalled so the block backs up
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic offer(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v, logic [IDX_W-1:0] sel);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sample <= v;
    bucket_sel <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen != items_sent);
  endtask

  task automatic program_range(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
                               logic [BT_W-1:0] nb);
    logic [VAL_W-1:0] pad;
    pad = $urandom;
    cfg_we <= 1'b1;
    cfg_idx <= REG_RANGE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx <= REG_RANGE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_idx <= REG_BUCKET_TOTAL;
    cfg_data <= {pad[VAL_W-1:BT_W], nb};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  function automatic logic [VAL_W-1:0] pick_inside();
    longint     span;
    logic [63:0] r;
    span = longint'(cur_hi) - longint'(cur_lo);
    r = {$urandom, $urandom};
    return VAL_W'(longint'(cur_lo) + longint'(r[62:0]) % span);
  endfunction

  task automatic random_setup();
    int               kind;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [BT_W-1:0]  nb;
    kind = $urandom_range(5);
    case ($urandom_range(3))
      0:       nb = '0;
      1:       nb = BT_W'($urandom_range(65, 127));
      default: nb = BT_W'($urandom_range(1, 64));
    endcase
    case (kind)
      0, 1: begin
        lo = $urandom_range(20000) - 10000;
        hi = lo + ((nb == 0) ? 1 : nb) * $urandom_range(1, 64);
      end
      2: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      3: begin
        lo = $urandom;
        hi = $urandom;
      end
      4: begin
        lo = $urandom;
        hi = lo - $urandom_range(1000);
      end
      default: begin
        lo = $urandom_range(1000);
        hi = lo + $urandom_range(1, 8);
      end
    endcase
    program_range(lo, hi, nb);
  endtask

  task automatic random_item();
    int               r;
    logic [VAL_W-1:0] v;
    r = $urandom_range(99);
    if (r < 68 && cur_hi > cur_lo) begin
      offer(CMD_ADD, pick_inside(), IDX_W'($urandom));
    end else if (r < 78) begin
      offer(CMD_ADD, $urandom, IDX_W'($urandom));
    end else if (r < 83) begin
      case ($urandom_range(3))
        0:       v = cur_lo;
        1:       v = cur_hi - 1;
        2:       v = cur_hi;
        default: v = cur_lo - 1;
      endcase
      offer(CMD_ADD, v, IDX_W'($urandom));
    end else if (r < 96) begin
      offer(CMD_READ, $urandom, IDX_W'($urandom));
    end else if (r < 97) begin
      offer(CMD_CLEAR, $urandom, IDX_W'($urandom));
    end else begin
      offer(CMD_NOP, $urandom, IDX_W'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset range: 0.0 .. 12.0, twelve buckets one unit wide
    offer(CMD_READ, '0, '0);
    offer(CMD_ADD, 32'd0, '0);
    offer(CMD_ADD, 32'd3071, '1);
    offer(CMD_ADD, 32'd3072, '0);
    offer(CMD_ADD, 32'hffff_ffff, '0);
    offer(CMD_ADD, 32'h7fff_ffff, '0);
    offer(CMD_ADD, 32'h8000_0000, '0);
    offer(CMD_READ, '0, 6'd11);
    offer(CMD_READ, '1, 6'd12);
    offer(CMD_READ, '0, 6'd63);
    offer(CMD_NOP, '1, '1);
    offer(CMD_CLEAR, '0, '0);
    // peak ties go to the lower bucket
    offer(CMD_ADD, 32'd768, '0);
    offer(CMD_ADD, 32'd256, '0);
    offer(CMD_ADD, 32'd255, '0);
    offer(CMD_READ, '0, 6'd1);
    drain();

    program_range(32'h8000_0000, 32'h7fff_ffff, 7'd64);
    offer(CMD_ADD, 32'h8000_0000, '0);
    offer(CMD_ADD, 32'h7fff_fffe, '0);
    offer(CMD_ADD, 32'h7fff_ffff, '0);
    offer(CMD_READ, '0, 6'd63);
    drain();

    program_range(32'd100, 32'd100, 7'd0);
    offer(CMD_ADD, 32'd100, '0);
    drain();

    program_range(32'hffff_ff00, 32'd256, 7'd0);
    offer(CMD_ADD, 32'hffff_ff00, '0);
    offer(CMD_READ, '0, 6'd1);
    drain();

    program_range(32'd0, 32'd3072, 7'd127);
    offer(CMD_READ, '0, 6'd63);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      random_setup();
      if ($urandom_range(3) == 0) offer(CMD_CLEAR, $urandom, IDX_W'($urandom));
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/uhb_pkg.sv
src/uhb_ctrl.sv
src/uhb_dp.sv
src/uniform_histogram_binner_unit.sv
tb/uhb_histogram_check.sv
tb/tb_top.sv
